// ===== rtl/tdss_pkg.sv =====
// ----------------------------------------------------------------------------
// tdss_pkg
// Shared types, codes and the segment table of the three-digit display scanner.
// ----------------------------------------------------------------------------
package tdss_pkg;

  localparam int CaptureWidthDefault = 16;
  localparam int DwellWidth          = 16;
  localparam int ResidWidth          = 15;

  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_CAPTURE = 1'b1;

  localparam logic REG_TICKS_PER_DIGIT = 1'b0;

  localparam logic [3:0] DIGIT_BLANK = 4'd10;

  localparam logic [2:0] EN_HUNDREDS = 3'b001;
  localparam logic [2:0] EN_TENS     = 3'b010;
  localparam logic [2:0] EN_ONES     = 3'b100;
  localparam logic [2:0] EN_NONE     = 3'b000;

  localparam logic [7:0] SEG_BLANK = 8'hFF;

  typedef enum logic [1:0] {
    SEL_HUNDREDS = 2'd0,
    SEL_TENS     = 2'd1,
    SEL_ONES     = 2'd2
  } digit_sel_t;

  // resid is congruent to the captured value modulo 100
  typedef struct packed {
    logic                  req_type;
    logic [3:0]            hundreds;
    logic [ResidWidth-1:0] resid;
  } split_t;

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h40;
      4'd1:    s = 8'h79;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'h30;
      4'd4:    s = 8'h19;
      4'd5:    s = 8'h12;
      4'd6:    s = 8'h02;
      4'd7:    s = 8'h78;
      4'd8:    s = 8'h00;
      4'd9:    s = 8'h18;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/tdss_split.sv =====
// ----------------------------------------------------------------------------
// tdss_split
// Second pipeline stage: hundreds digit and a 15-bit residue mod 100 of the
// captured value.
// ----------------------------------------------------------------------------
module tdss_split #(
  parameter int CAPTURE_WIDTH = tdss_pkg::CaptureWidthDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_req_type,
  input  logic [CAPTURE_WIDTH-1:0] in_value,
  input  logic                     out_free,
  output logic                     in_free,
  output logic                     out_valid,
  output tdss_pkg::split_t         out_data
);
  import tdss_pkg::*;

  logic [31:0]           v32;
  logic [15:0]           h_prod;
  logic [ResidWidth-1:0] resid;
  split_t                data_next;

  // bytes weighted by 256^i mod 100 = 1, 56, 36, 16
  always_comb begin
    v32    = 32'(in_value);
    resid  = ResidWidth'(v32[7:0])
           + ResidWidth'({v32[15:8], 5'b0}) + ResidWidth'({v32[15:8], 4'b0})
           + ResidWidth'({v32[15:8], 3'b0})
           + ResidWidth'({v32[23:16], 5'b0}) + ResidWidth'({v32[23:16], 2'b0})
           + ResidWidth'({v32[31:24], 4'b0});
    // v / 100 == (v * 41) >> 12 for v below 1000
    h_prod = 16'({v32[9:0], 5'b0}) + 16'({v32[9:0], 3'b0}) + 16'(v32[9:0]);
    data_next.req_type = in_req_type;
    data_next.hundreds = (v32 >= 32'd1000) ? DIGIT_BLANK : h_prod[15:12];
    data_next.resid    = resid;
  end

  assign in_free = !out_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== rtl/tdss_scan.sv =====
// ----------------------------------------------------------------------------
// tdss_scan
// Digit store, scan timer and result register.
// ----------------------------------------------------------------------------
module tdss_scan (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  tdss_pkg::split_t                in_data,
  input  logic [tdss_pkg::DwellWidth-1:0] ticks_per_digit,
  input  logic                            res_stall,
  output logic                            in_free,
  output logic                            res_valid,
  output logic [7:0]                      segment_pattern,
  output logic [2:0]                      digit_enable
);
  import tdss_pkg::*;

  logic [3:0]            hundreds_digit, tens_digit, ones_digit;
  logic [3:0]            hundreds_digit_next, tens_digit_next, ones_digit_next;
  digit_sel_t            active_digit, active_digit_next;
  logic [DwellWidth-1:0] dwell_count, dwell_count_next;

  logic [27:0]           q_prod;
  logic [8:0]            q;
  logic [ResidWidth-1:0] q_times_100;
  logic [6:0]            rem;
  logic [3:0]            rem_tens, rem_ones;
  logic [DwellWidth-1:0] limit;
  logic [DwellWidth:0]   dwell_inc;
  logic [3:0]            shown;
  logic [2:0]            enable_next;
  logic                  load;

  assign in_free = !res_valid || !res_stall;
  assign load    = in_valid && in_free;

  always_comb begin
    // resid / 100 == (resid * 5243) >> 19 over the residue range
    q_prod      = 28'(in_data.resid) * 28'd5243;
    q           = q_prod[27:19];
    q_times_100 = ResidWidth'({q, 6'b0}) + ResidWidth'({q, 5'b0})
                + ResidWidth'({q, 2'b0});
    rem         = 7'(in_data.resid - q_times_100);
    rem_tens    = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= 7'(10 * k)) rem_tens = 4'(k);
    end
    rem_ones = 4'(rem - 7'({rem_tens, 3'b0}) - 7'({rem_tens, 1'b0}));

    hundreds_digit_next = hundreds_digit;
    tens_digit_next     = tens_digit;
    ones_digit_next     = ones_digit;
    active_digit_next   = active_digit;
    dwell_count_next    = dwell_count;
    limit               = (ticks_per_digit == '0) ? DwellWidth'(1) : ticks_per_digit;
    dwell_inc           = {1'b0, dwell_count} + (DwellWidth + 1)'(1);

    if (in_data.req_type == REQ_CAPTURE) begin
      hundreds_digit_next = in_data.hundreds;
      tens_digit_next     = rem_tens;
      ones_digit_next     = rem_ones;
    end else if (dwell_inc >= {1'b0, limit}) begin
      dwell_count_next = '0;
      unique case (active_digit)
        SEL_HUNDREDS: active_digit_next = SEL_TENS;
        SEL_TENS:     active_digit_next = SEL_ONES;
        default:      active_digit_next = SEL_HUNDREDS;
      endcase
    end else begin
      dwell_count_next = dwell_inc[DwellWidth-1:0];
    end

    unique case (active_digit_next)
      SEL_HUNDREDS: begin shown = hundreds_digit_next; enable_next = EN_HUNDREDS; end
      SEL_TENS:     begin shown = tens_digit_next;     enable_next = EN_TENS;     end
      SEL_ONES:     begin shown = ones_digit_next;     enable_next = EN_ONES;     end
      default:      begin shown = DIGIT_BLANK;         enable_next = EN_NONE;     end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hundreds_digit <= DIGIT_BLANK;
      tens_digit     <= DIGIT_BLANK;
      ones_digit     <= DIGIT_BLANK;
      active_digit   <= SEL_HUNDREDS;
      dwell_count    <= '0;
      res_valid      <= 1'b0;
    end else if (load) begin
      hundreds_digit <= hundreds_digit_next;
      tens_digit     <= tens_digit_next;
      ones_digit     <= ones_digit_next;
      active_digit   <= active_digit_next;
      dwell_count    <= dwell_count_next;
      res_valid      <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      segment_pattern <= seg_of(shown);
      digit_enable    <= enable_next;
    end
  end

  a_enable_onehot: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot(digit_enable))
    else $error("digit enable not one-hot on a valid result");

  a_capture_keeps_scan: assert property (@(posedge clk) disable iff (rst)
    (load && in_data.req_type == REQ_CAPTURE) |=> $stable(active_digit) && $stable(dwell_count))
    else $error("capture changed the scan position");

  a_step_clears_dwell: assert property (@(posedge clk) disable iff (rst)
    (load && in_data.req_type == REQ_TICK && active_digit_next != active_digit)
      |=> dwell_count == '0)
    else $error("scan step left dwell count nonzero");

  a_digits_in_range: assert property (@(posedge clk) disable iff (rst)
    tens_digit <= DIGIT_BLANK && ones_digit <= DIGIT_BLANK && hundreds_digit <= DIGIT_BLANK)
    else $error("stored digit out of range");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> res_valid && $stable(segment_pattern))
    else $error("stalled result changed");

endmodule

// ===== rtl/three_digit_segment_display_scanner.sv =====
// ----------------------------------------------------------------------------
// three_digit_segment_display_scanner
// Three-digit multiplexed seven-segment scanner with captured-value display.
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall): each transfer is either a time tick
// (req_type 0) or a new captured value (req_type 1, capture_value). A capture
// splits the value into hundreds, tens and ones; hundreds above 9 shows blank.
// Ticks scan hundreds, tens, ones, each lit for ticks_per_digit ticks.
// Result channel (res_valid / res_stall): one transfer per request, carrying
// the active-low segment_pattern and the one-hot digit_enable of the digit
// being scanned after that request.
// One request per cycle is sustained while res_stall is low, through a
// three-register pipeline (input register, digit-split register, result
// register). When res_stall is high the pipeline fills and bubbles collapse;
// req_stall rises once all three registers hold items.
// Reset: digits blank, scan on hundreds, dwell count zero, ticks_per_digit 1.
// APB: ticks_per_digit at byte address 0. The user must write it only while
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module three_digit_segment_display_scanner #(
  parameter int CAPTURE_WIDTH = tdss_pkg::CaptureWidthDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic                     req_type,
  input  logic [CAPTURE_WIDTH-1:0] capture_value,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic [7:0]               segment_pattern,
  output logic [2:0]               digit_enable,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import tdss_pkg::*;

  logic                     s1_valid;
  logic                     s1_req_type;
  logic [CAPTURE_WIDTH-1:0] s1_value;
  logic                     s1_free;
  logic                     s2_free;
  logic                     s2_valid;
  logic                     scan_free;
  split_t                   s2_data;
  logic [DwellWidth-1:0]    ticks_per_digit;
  logic                     cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_TICKS_PER_DIGIT) ? 32'(ticks_per_digit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_digit <= DwellWidth'(1);
    end else if (cfg_write && paddr[2] == REG_TICKS_PER_DIGIT) begin
      ticks_per_digit <= pwdata[DwellWidth-1:0];
    end
  end

  assign s1_free   = !s1_valid || s2_free;
  assign req_stall = !s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && req_valid) begin
      s1_req_type <= req_type;
      s1_value    <= capture_value;
    end
  end

  tdss_split #(
    .CAPTURE_WIDTH(CAPTURE_WIDTH)
  ) u_split (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s1_valid),
    .in_req_type(s1_req_type),
    .in_value   (s1_value),
    .out_free   (scan_free),
    .in_free    (s2_free),
    .out_valid  (s2_valid),
    .out_data   (s2_data)
  );

  tdss_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s2_valid),
    .in_data        (s2_data),
    .ticks_per_digit(ticks_per_digit),
    .res_stall      (res_stall),
    .in_free        (scan_free),
    .res_valid      (res_valid),
    .segment_pattern(segment_pattern),
    .digit_enable   (digit_enable)
  );

endmodule

// ===== tb/three_digit_segment_display_scanner_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_digit_segment_display_scanner_test
// Self-checking bench for the three-digit seven-segment scanner.
// Ticks and captures are sent through the request channel. A local model of
// the digit store and the scan timer predicts every segment pattern and digit
// enable, and each result transfer is compared against it in order. Both
// channels idle at random. The dwell register is rewritten between phases.
// ----------------------------------------------------------------------------
module three_digit_segment_display_scanner_test;
  import tdss_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_WAIT    = 11;
  localparam int PHASE_ITEMS = 242;

  // active-low patterns, digit 9 down to digit 0
  localparam logic [9:0][7:0] SEG_CODE = {
    8'h18, 8'h00, 8'h78, 8'h02, 8'h12, 8'h19, 8'h30, 8'hA4, 8'h79, 8'h40
  };
  localparam logic [5:0][15:0] DWELL_PLAN = {
    16'd4, 16'd0, 16'd3, 16'd2, 16'd1, 16'd65535
  };
  localparam logic [2:0] TICKS_ADDR = {REG_TICKS_PER_DIGIT, 2'b00};

  typedef struct packed {
    logic [7:0] seg;
    logic [2:0] en;
  } lit_t;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic        req_type;
  logic [15:0] capture_value;
  logic        res_valid;
  logic        res_stall;
  logic [7:0]  segment_pattern;
  logic [2:0]  digit_enable;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [15:0] ticks_cfg;
  logic [3:0]  hund_d;
  logic [3:0]  tens_d;
  logic [3:0]  ones_d;
  digit_sel_t  scan_sel;
  logic [15:0] dwell;

  lit_t pending_lit[$];
  lit_t want_lit;
  int   errors;
  int   cycles;
  int   res_hold;
  bit   req_idling;
  bit   res_idling;

  three_digit_segment_display_scanner dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_type(req_type),
    .capture_value(capture_value),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .segment_pattern(segment_pattern),
    .digit_enable(digit_enable),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic lit_t scan_step(input logic kind, input logic [15:0] value);
    int unsigned v;
    int unsigned h;
    int unsigned limit;
    logic [3:0]  d;
    lit_t        r;
    v = value;
    if (kind == REQ_CAPTURE) begin
      h = v / 100;
      hund_d = (h > 9) ? DIGIT_BLANK : 4'(h);
      tens_d = 4'((v % 100) / 10);
      ones_d = 4'(v % 10);
    end else begin
      limit = (ticks_cfg == 16'd0) ? 1 : ticks_cfg;
      if (int'(dwell) + 1 >= int'(limit)) begin
        dwell = 16'd0;
        scan_sel = (scan_sel == SEL_ONES) ? SEL_HUNDREDS : digit_sel_t'(scan_sel + 2'd1);
      end else begin
        dwell = dwell + 16'd1;
      end
    end
    case (scan_sel)
      SEL_HUNDREDS: begin d = hund_d; r.en = EN_HUNDREDS; end
      SEL_TENS: begin d = tens_d; r.en = EN_TENS; end
      SEL_ONES: begin d = ones_d; r.en = EN_ONES; end
      default: begin d = 4'd15; r.en = EN_NONE; end
    endcase
    r.seg = (d < 4'd10) ? SEG_CODE[d] : SEG_BLANK;
    return r;
  endfunction

  task automatic send_request(input logic kind, input logic [15:0] value);
    int gap;
    gap = req_idling ? $urandom_range(0, MAX_WAIT) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid     <= 1'b1;
    req_type      <= kind;
    capture_value <= value;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_lit.push_back(scan_step(kind, value));
  endtask

  task automatic drain;
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_lit.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ticks(input logic [15:0] value);
    drain();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TICKS_ADDR;
    pwdata  <= {16'h0000, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    ticks_cfg = value;
    // read back
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {16'h0000, value}) begin
      errors++;
      $display("%0t: ticks_per_digit read expected %h got %h", $time,
               {16'h0000, value}, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_blank;
    repeat (4) send_request(REQ_TICK, 16'h0000);
  endtask

  task automatic test_capture_extremes;
    logic [6:0][15:0] values;
    values = {16'd42, 16'd5, 16'd100, 16'd65535, 16'd1000, 16'd999, 16'd0};
    for (int i = 0; i < 7; i++) begin
      send_request(REQ_CAPTURE, values[i]);
      send_request(REQ_TICK, 16'hFFFF);
    end
  endtask

  task automatic test_zero_dwell;
    write_ticks(16'd0);
    repeat (3) send_request(REQ_TICK, 16'h0000);
  endtask

  task automatic test_dwell_lowered;
    write_ticks(16'd5);
    repeat (3) send_request(REQ_TICK, 16'h0000);
    write_ticks(16'd2);
    send_request(REQ_TICK, 16'h0000);
  endtask

  task automatic test_random_traffic;
    logic        kind;
    logic [15:0] value;
    for (int p = 0; p < 6; p++) begin
      write_ticks(DWELL_PLAN[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) begin
          req_idling = $urandom_range(0, 1);
          res_idling = $urandom_range(0, 1);
        end
        kind = ($urandom_range(0, 9) < 3) ? REQ_CAPTURE : REQ_TICK;
        case ($urandom_range(0, 3))
          0: value = 16'($urandom_range(0, 999));
          1: value = 16'($urandom_range(990, 1010));
          2: value = 16'($urandom_range(0, 99));
          default: value = 16'($urandom_range(0, 65535));
        endcase
        send_request(kind, value);
      end
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[three_digit_segment_display_scanner] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_lit.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none got seg %h en %b", $time,
                 segment_pattern, digit_enable);
      end else begin
        want_lit = pending_lit.pop_front();
        if (segment_pattern !== want_lit.seg) begin
          errors++;
          $display("%0t: segment_pattern expected %h got %h", $time,
                   want_lit.seg, segment_pattern);
        end
        if (digit_enable !== want_lit.en) begin
          errors++;
          $display("%0t: digit_enable expected %b got %b", $time,
                   want_lit.en, digit_enable);
        end
      end
      res_hold = res_idling ? $urandom_range(0, MAX_WAIT) : 0;
    end
  end

  always @(negedge clk) begin
    if (res_hold > 0) begin
      res_stall <= 1'b1;
      res_hold--;
    end else begin
      res_stall <= 1'b0;
    end
  end

  initial begin
    rst           = 1'b1;
    req_valid     = 1'b0;
    req_type      = REQ_TICK;
    capture_value = 16'h0000;
    res_stall     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = TICKS_ADDR;
    pwdata        = 32'h0;
    errors        = 0;
    cycles        = 0;
    res_hold      = 0;
    req_idling    = 1'b1;
    res_idling    = 1'b1;
    ticks_cfg     = 16'd1;
    hund_d        = DIGIT_BLANK;
    tens_d        = DIGIT_BLANK;
    ones_d        = DIGIT_BLANK;
    scan_sel      = SEL_HUNDREDS;
    dwell         = 16'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_blank();
    test_capture_extremes();
    test_zero_dwell();
    test_dwell_lowered();
    test_random_traffic();

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[three_digit_segment_display_scanner] OK");
    end else begin
      $display("[three_digit_segment_display_scanner] ERROR");
    end
    $finish;
  end

endmodule
